### sv/uartrb_pkg.sv
// Shared request codes and controller/datapath handshake types for the UART ring buffers.
package uartrb_pkg;

    localparam int REQ_W  = 3;
    localparam int BYTE_W = 8;
    localparam int AVAIL_W = 7;

    localparam logic [REQ_W-1:0] REQ_SEND    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_GET     = 3'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RX_BYTE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_TX_DONE = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WRITE = 4'b0010,
        ST_READ  = 4'b0100,
        ST_RESP  = 4'b1000
    } ctrl_state_t;

    typedef struct packed {
        logic latch;
        logic rx_put;
        logic tx_put;
        logic rx_read;
        logic rx_pop;
        logic tx_read;
        logic tx_pop;
        logic set_idle;
        logic clr_idle;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             rx_good;
        logic             rx_empty;
        logic             tx_empty;
        logic             tx_idle;
        logic             out_free;
    } dp_status_t;

endpackage

### sv/uartrb_if.sv
// Valid/ready channel interfaces for request words and result words.
interface uartrb_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] req_type;
    logic [7:0] data_byte;
    logic       frame_error;
    logic       parity_error;
    logic       rx_present;

    modport source (
        output valid, req_type, data_byte, frame_error, parity_error, rx_present,
        input  ready
    );
    modport sink (
        input  valid, req_type, data_byte, frame_error, parity_error, rx_present,
        output ready
    );
endinterface

interface uartrb_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic [6:0] rx_available;
    logic       tx_load;
    logic [7:0] tx_byte;

    modport source (
        output valid, read_byte, rx_available, tx_load, tx_byte,
        input  ready
    );
    modport sink (
        input  valid, read_byte, rx_available, tx_load, tx_byte,
        output ready
    );
endinterface

### sv/uart_rx_tx_ring_buffers_top.sv
// Top level of the UART receive/transmit ring buffers.
// Usage:
// - item (sink) carries one request word: host send, host get, host peek,
//   byte received from the line, or transmitter done.
// - result (source) returns exactly one word per request: the byte from a
//   get or peek, the receive fill level, and the byte handed to the
//   transmitter when tx_load is set.
// - Each word goes through accept, ring write, registered RAM read and
//   result load; no new word is taken until the result of the last one
//   has been loaded into the result register. The write-then-read order
//   through each ring's RAM sets this sequence.
// - Full buffers overwrite their oldest byte; a get on an empty receive
//   buffer returns 0.
// - Reset clears pointers, counts and the result valid flag and marks the
//   transmitter idle. Entries never written read as zero through a wrap
//   flag per ring, so no clearing pass runs after reset.
// - When result.ready is low the finished word waits in the result
//   register; one further request can be accepted and held until the
//   register frees, after which item.ready stays low.
module uart_rx_tx_ring_buffers_top #(
    parameter int BUF_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    uartrb_in_if.sink    item,
    uartrb_out_if.source result
);

    uartrb_pkg::dp_cmd_t    cmd;
    uartrb_pkg::dp_status_t status;

    uartrb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (status),
        .cmd      (cmd)
    );

    uartrb_dp #(.BUF_DEPTH(BUF_DEPTH)) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .status (status)
    );

endmodule

### sv/uartrb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module uartrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/uartrb_ring.sv
// One byte ring buffer: pointers, count and RAM, overwriting the oldest byte when full.
module uartrb_ring #(
    parameter int DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       put,
    input  logic [7:0]                 wdata,
    input  logic                       read,
    input  logic                       pop,
    output logic [7:0]                 rd_byte,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;
    // set once the head has wrapped: every entry has been written since reset
    logic             wrapped_reg, wrapped_next;
    logic             rvalid_reg, rvalid_next;
    logic [7:0]       ram_rdata;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    always_comb
    begin
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        wrapped_next = wrapped_reg;
        rvalid_next  = rvalid_reg;
        if (put)
        begin
            head_next = ptr_inc(head_reg);
            if (head_reg == PTR_LAST)
            begin
                wrapped_next = 1'b1;
            end
            if (count_reg != CNT_FULL)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                tail_next = ptr_inc(tail_reg);
            end
        end
        else if (read)
        begin
            // never-written entries read as zero
            rvalid_next = wrapped_reg || (tail_reg < head_reg);
            if (pop)
            begin
                tail_next  = ptr_inc(tail_reg);
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            wrapped_reg <= 1'b0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            wrapped_reg <= wrapped_next;
            rvalid_reg  <= rvalid_next;
        end
    end

    uartrb_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (put),
        .waddr (head_reg),
        .wdata (wdata),
        .re    (read),
        .raddr (tail_reg),
        .rdata (ram_rdata)
    );

    assign rd_byte = rvalid_reg ? ram_rdata : 8'd0;
    assign count   = count_reg;
    assign empty   = (count_reg == '0);

endmodule

### sv/uartrb_dp.sv
// Datapath: request latch, both rings, transmitter-idle flag and result register.
module uartrb_dp #(
    parameter int BUF_DEPTH = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    uartrb_in_if.sink            item,
    uartrb_out_if.source         result,
    input  uartrb_pkg::dp_cmd_t  cmd,
    output uartrb_pkg::dp_status_t status
);

    localparam int CNT_W = $clog2(BUF_DEPTH + 1);

    logic [uartrb_pkg::REQ_W-1:0] req_reg;
    logic [7:0]                   data_reg;
    logic                         good_reg;
    logic                         tx_idle_reg;
    logic                         rx_used_reg;
    logic                         tx_used_reg;

    logic                         out_valid_reg;
    logic [7:0]                   out_read_reg;
    logic [uartrb_pkg::AVAIL_W-1:0] out_avail_reg;
    logic                         out_load_reg;
    logic [7:0]                   out_txb_reg;

    logic [7:0]       rx_rd_byte, tx_rd_byte;
    logic [CNT_W-1:0] rx_count, tx_count;
    logic             rx_empty, tx_empty;
    logic [CNT_W+uartrb_pkg::AVAIL_W-1:0] avail_wide;

    // item payload, taken on accept
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            req_reg  <= item.req_type;
            data_reg <= item.data_byte;
            good_reg <= !item.frame_error && !item.parity_error && item.rx_present;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_idle_reg <= 1'b1;
            rx_used_reg <= 1'b0;
            tx_used_reg <= 1'b0;
        end
        else
        begin
            if (cmd.set_idle)
            begin
                tx_idle_reg <= 1'b1;
            end
            else if (cmd.clr_idle)
            begin
                tx_idle_reg <= 1'b0;
            end
            if (cmd.latch)
            begin
                rx_used_reg <= 1'b0;
                tx_used_reg <= 1'b0;
            end
            else
            begin
                if (cmd.rx_read)
                begin
                    rx_used_reg <= 1'b1;
                end
                if (cmd.tx_read)
                begin
                    tx_used_reg <= 1'b1;
                end
            end
        end
    end

    uartrb_ring #(.DEPTH(BUF_DEPTH)) u_rx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .put     (cmd.rx_put),
        .wdata   (data_reg),
        .read    (cmd.rx_read),
        .pop     (cmd.rx_pop),
        .rd_byte (rx_rd_byte),
        .count   (rx_count),
        .empty   (rx_empty)
    );

    uartrb_ring #(.DEPTH(BUF_DEPTH)) u_tx_ring (
        .clk     (clk),
        .rst_n   (rst_n),
        .put     (cmd.tx_put),
        .wdata   (data_reg),
        .read    (cmd.tx_read),
        .pop     (cmd.tx_pop),
        .rd_byte (tx_rd_byte),
        .count   (tx_count),
        .empty   (tx_empty)
    );

    // count reported modulo 128
    assign avail_wide = {{uartrb_pkg::AVAIL_W{1'b0}}, rx_count};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_read_reg  <= rx_used_reg ? rx_rd_byte : 8'd0;
            out_avail_reg <= avail_wide[uartrb_pkg::AVAIL_W-1:0];
            out_load_reg  <= tx_used_reg;
            out_txb_reg   <= tx_used_reg ? tx_rd_byte : 8'd0;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.read_byte    = out_read_reg;
    assign result.rx_available = out_avail_reg;
    assign result.tx_load      = out_load_reg;
    assign result.tx_byte      = out_txb_reg;

    assign status.req      = req_reg;
    assign status.rx_good  = good_reg;
    assign status.rx_empty = rx_empty;
    assign status.tx_empty = tx_empty;
    assign status.tx_idle  = tx_idle_reg;
    assign status.out_free = !out_valid_reg || result.ready;

    // tx count is not used; it is only reduced here
    logic unused_tx_count;
    assign unused_tx_count = ^tx_count;

endmodule

### sv/uartrb_ctrl.sv
// Controller: sequences accept, ring write, ring read and result load for each word.
module uartrb_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  uartrb_pkg::dp_status_t status,
    output uartrb_pkg::dp_cmd_t    cmd
);

    uartrb_pkg::ctrl_state_t state_reg, state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        case (state_reg)
            uartrb_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = uartrb_pkg::ST_WRITE;
                end
            end
            uartrb_pkg::ST_WRITE:
            begin
                case (status.req)
                    uartrb_pkg::REQ_SEND:    cmd.tx_put = 1'b1;
                    uartrb_pkg::REQ_RX_BYTE: cmd.rx_put = status.rx_good;
                    default:                 cmd.tx_put = 1'b0;
                endcase
                state_next = uartrb_pkg::ST_READ;
            end
            uartrb_pkg::ST_READ:
            begin
                case (status.req)
                    uartrb_pkg::REQ_SEND:
                    begin
                        // queue is non-empty after the put
                        if (status.tx_idle)
                        begin
                            cmd.tx_read  = 1'b1;
                            cmd.tx_pop   = 1'b1;
                            cmd.clr_idle = 1'b1;
                        end
                    end
                    uartrb_pkg::REQ_GET:
                    begin
                        if (!status.rx_empty)
                        begin
                            cmd.rx_read = 1'b1;
                            cmd.rx_pop  = 1'b1;
                        end
                    end
                    uartrb_pkg::REQ_PEEK:
                    begin
                        cmd.rx_read = 1'b1;
                    end
                    uartrb_pkg::REQ_TX_DONE:
                    begin
                        if (!status.tx_empty)
                        begin
                            cmd.tx_read = 1'b1;
                            cmd.tx_pop  = 1'b1;
                        end
                        else
                        begin
                            cmd.set_idle = 1'b1;
                        end
                    end
                    default:
                    begin
                        cmd.rx_read = 1'b0;
                    end
                endcase
                state_next = uartrb_pkg::ST_RESP;
            end
            uartrb_pkg::ST_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = uartrb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = uartrb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= uartrb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### tb/uart_rx_tx_ring_buffers_top_tb.sv
// Self-checking testbench for the UART receive/transmit ring buffers top level.
`timescale 1ns / 1ps

module uart_rx_tx_ring_buffers_top_tb;

    localparam int  CLK_PERIOD   = 12;
    localparam int  RESET_CYCLES = 11;
    localparam int  DEPTH        = 64;
    localparam int  PTR_W        = $clog2(DEPTH);
    localparam int  RING_RX      = 0;
    localparam int  RING_TX      = 1;
    localparam int  STALL_CYCLES = 80;
    localparam int  DRAIN_CYCLES = 20;
    localparam int  NUM_PHASES   = 10;
    localparam int  TIMEOUT_NS   = 3_000_000;
    localparam bit  CHK_TYPED    = 1'b1;
    localparam bit  CHK_MODEL    = 1'b0;

    // request codes the block treats as no-ops
    localparam logic [uartrb_pkg::REQ_W-1:0] REQ_SPARE_LO = 3'd5;
    localparam logic [uartrb_pkg::REQ_W-1:0] REQ_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [uartrb_pkg::REQ_W-1:0]  req;
        logic [uartrb_pkg::BYTE_W-1:0] data;
        logic                          fe;
        logic                          pe;
        logic                          pr;
    } req_word_t;

    typedef struct packed {
        logic [uartrb_pkg::BYTE_W-1:0]  rd;
        logic [uartrb_pkg::AVAIL_W-1:0] avail;
        logic                           load;
        logic [uartrb_pkg::BYTE_W-1:0]  txb;
    } res_word_t;

    typedef struct packed {
        req_word_t w;
        logic      typed;
        res_word_t r;
    } dir_row_t;

    typedef enum int {PH_FILL, PH_MIX, PH_DRAIN, PH_NOISE} phase_t;

    logic clk = 1'b0;
    logic rst_n;

    uartrb_in_if  item();
    uartrb_out_if result();

    uart_rx_tx_ring_buffers_top #(.BUF_DEPTH(DEPTH)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // sideband travelling with each word: typed-in expectation for directed rows
    logic      word_typed;
    res_word_t word_typed_res;

    // shadow copy of both rings and the transmitter flag
    logic [uartrb_pkg::BYTE_W-1:0]  ring_mem  [2][DEPTH];
    logic [PTR_W-1:0]               ring_wr   [2];
    logic [PTR_W-1:0]               ring_rd   [2];
    logic [uartrb_pkg::AVAIL_W-1:0] ring_fill [2];
    logic                           tx_quiet;

    res_word_t expect_q [$];
    dir_row_t  dir_rows [$];

    int  errors;
    int  words_taken;
    int  results_checked;
    int  overwrites [2];
    int  tx_loads;
    int  peak_rx_fill;
    int  stalls_done;
    int  burst_left;
    bit  stall_req;

    function automatic void put_byte(input int r, input logic [uartrb_pkg::BYTE_W-1:0] b);
        ring_mem[r][ring_wr[r]] = b;
        ring_wr[r] = ring_wr[r] + 1'b1;
        if (int'(ring_fill[r]) < DEPTH)
            ring_fill[r] = ring_fill[r] + 1'b1;
        else
        begin
            // full: oldest byte is dropped
            ring_rd[r] = ring_rd[r] + 1'b1;
            overwrites[r]++;
        end
    endfunction

    function automatic logic [uartrb_pkg::BYTE_W-1:0] take_byte(input int r);
        logic [uartrb_pkg::BYTE_W-1:0] b;
        if (ring_fill[r] == '0)
            return '0;
        b = ring_mem[r][ring_rd[r]];
        ring_rd[r] = ring_rd[r] + 1'b1;
        ring_fill[r] = ring_fill[r] - 1'b1;
        return b;
    endfunction

    function automatic res_word_t step_rings(input req_word_t w);
        res_word_t o;
        o = '0;
        case (w.req)
            uartrb_pkg::REQ_SEND:
            begin
                put_byte(RING_TX, w.data);
                if (tx_quiet)
                begin
                    tx_quiet = 1'b0;
                    o.txb  = take_byte(RING_TX);
                    o.load = 1'b1;
                end
            end
            uartrb_pkg::REQ_GET:
                o.rd = take_byte(RING_RX);
            uartrb_pkg::REQ_PEEK:
                o.rd = ring_mem[RING_RX][ring_rd[RING_RX]];
            uartrb_pkg::REQ_RX_BYTE:
                if (!w.fe && !w.pe && w.pr)
                    put_byte(RING_RX, w.data);
            uartrb_pkg::REQ_TX_DONE:
                if (ring_fill[RING_TX] != '0)
                begin
                    o.txb  = take_byte(RING_TX);
                    o.load = 1'b1;
                end
                else
                    tx_quiet = 1'b1;
            default: ;
        endcase
        o.avail = ring_fill[RING_RX];
        if (o.load)
            tx_loads++;
        if (int'(ring_fill[RING_RX]) > peak_rx_fill)
            peak_rx_fill = int'(ring_fill[RING_RX]);
        return o;
    endfunction

    function automatic void dir_row(input logic [uartrb_pkg::REQ_W-1:0] req,
                                    input logic [uartrb_pkg::BYTE_W-1:0] data,
                                    input logic fe, input logic pe, input logic pr,
                                    input logic typed,
                                    input logic [uartrb_pkg::BYTE_W-1:0] rd,
                                    input logic [uartrb_pkg::AVAIL_W-1:0] avail,
                                    input logic load,
                                    input logic [uartrb_pkg::BYTE_W-1:0] txb);
        dir_row_t row;
        row.w     = {req, data, fe, pe, pr};
        row.typed = typed;
        row.r     = {rd, avail, load, txb};
        dir_rows.push_back(row);
    endfunction

    // offer one word inside the current burst; a new burst starts after a random gap
    task automatic offer_word(input req_word_t w, input logic typed, input res_word_t r);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 5);
            if (gap > 0)
            begin
                item.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 30);
        end
        burst_left--;
        item.valid        <= 1'b1;
        item.req_type     <= w.req;
        item.data_byte    <= w.data;
        item.frame_error  <= w.fe;
        item.parity_error <= w.pe;
        item.rx_present   <= w.pr;
        word_typed        <= typed;
        word_typed_res    <= r;
        @(posedge clk);
        while (!item.ready)
            @(posedge clk);
    endtask

    task automatic wait_all_back();
        item.valid <= 1'b0;
        @(posedge clk);
        wait (expect_q.size() == 0);
        @(posedge clk);
    endtask

    // predictor and checker, both sampled at the rising edge
    always @(posedge clk)
    begin : monitor
        req_word_t taken;
        res_word_t want;
        res_word_t got;
        if (rst_n)
        begin
            if (item.valid && item.ready)
            begin
                taken = {item.req_type, item.data_byte, item.frame_error,
                         item.parity_error, item.rx_present};
                want = step_rings(taken);
                words_taken++;
                expect_q.push_back(word_typed ? word_typed_res : want);
            end
            if (result.valid && result.ready)
            begin
                got = {result.read_byte, result.rx_available, result.tx_load, result.tx_byte};
                if (expect_q.size() == 0)
                begin
                    $display("%0t: result word with nothing pending: %h", $time, got);
                    errors++;
                end
                else
                begin
                    want = expect_q.pop_front();
                    results_checked++;
                    if (got.rd !== want.rd)
                    begin
                        $display("%0t: read_byte expected %h got %h", $time, want.rd, got.rd);
                        errors++;
                    end
                    if (got.avail !== want.avail)
                    begin
                        $display("%0t: rx_available expected %0d got %0d",
                                 $time, want.avail, got.avail);
                        errors++;
                    end
                    if (got.load !== want.load)
                    begin
                        $display("%0t: tx_load expected %b got %b", $time, want.load, got.load);
                        errors++;
                    end
                    if (got.txb !== want.txb)
                    begin
                        $display("%0t: tx_byte expected %h got %h", $time, want.txb, got.txb);
                        errors++;
                    end
                end
            end
        end
    end

    // result side: segments of always-ready, coin-flip and one-in-three stalls, plus a long stall on request
    initial
    begin : result_side
        int seg;
        int mode;
        int k;
        result.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (stall_req)
            begin
                result.ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
                stall_req = 1'b0;
                stalls_done++;
            end
            else
            begin
                seg  = $urandom_range(10, 80);
                mode = $urandom_range(0, 2);
                for (k = 0; k < seg && !stall_req; k++)
                begin
                    case (mode)
                        0:       result.ready <= 1'b1;
                        1:       result.ready <= 1'($urandom_range(0, 1));
                        default: result.ready <= (k % 3 != 2);
                    endcase
                    @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int        p;
        int        n;
        int        plen;
        int        roll;
        phase_t    ph;
        req_word_t w;
        dir_row_t  row;

        errors = 0;
        words_taken = 0;
        results_checked = 0;
        tx_loads = 0;
        peak_rx_fill = 0;
        stalls_done = 0;
        burst_left = 0;
        stall_req = 1'b0;
        tx_quiet = 1'b1;
        for (int r = 0; r < 2; r++)
        begin
            ring_wr[r] = '0;
            ring_rd[r] = '0;
            ring_fill[r] = '0;
            overwrites[r] = 0;
            for (int i = 0; i < DEPTH; i++)
                ring_mem[r][i] = '0;
        end

        rst_n = 1'b0;
        item.valid        <= 1'b0;
        item.req_type     <= uartrb_pkg::REQ_SEND;
        item.data_byte    <= '0;
        item.frame_error  <= 1'b0;
        item.parity_error <= 1'b0;
        item.rx_present   <= 1'b0;
        word_typed        <= 1'b0;
        word_typed_res    <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        //       req                      data   fe pe pr  check      rd     avail load txb
        dir_row(uartrb_pkg::REQ_PEEK,    8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_GET,     8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_TX_DONE, 8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_SEND,    8'hFF, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 1, 8'hFF);
        dir_row(uartrb_pkg::REQ_SEND,    8'h00, 1, 1, 1, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_SEND,    8'hA5, 0, 0, 0, CHK_MODEL, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_TX_DONE, 8'hFF, 1, 1, 1, CHK_MODEL, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_TX_DONE, 8'h00, 0, 0, 0, CHK_MODEL, 8'h00, 7'd0, 0, 8'h00);
        // queue drained: transmitter goes idle, then a done while idle
        dir_row(uartrb_pkg::REQ_TX_DONE, 8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_TX_DONE, 8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_SEND,    8'h5A, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 1, 8'h5A);
        dir_row(uartrb_pkg::REQ_TX_DONE, 8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        // errored or absent receive bytes are dropped
        dir_row(uartrb_pkg::REQ_RX_BYTE, 8'hFF, 1, 0, 1, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_RX_BYTE, 8'hFF, 0, 1, 1, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_RX_BYTE, 8'h81, 1, 1, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_RX_BYTE, 8'h7E, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_RX_BYTE, 8'hFF, 0, 0, 1, CHK_TYPED, 8'h00, 7'd1, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_RX_BYTE, 8'h00, 0, 0, 1, CHK_TYPED, 8'h00, 7'd2, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_PEEK,    8'h00, 0, 0, 0, CHK_TYPED, 8'hFF, 7'd2, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_GET,     8'h00, 0, 0, 0, CHK_TYPED, 8'hFF, 7'd1, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_GET,     8'hFF, 1, 1, 1, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(uartrb_pkg::REQ_GET,     8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        // peek on empty reads zero, as the slot at the tail was never written
        dir_row(uartrb_pkg::REQ_PEEK,    8'h00, 0, 0, 0, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(REQ_SPARE_LO,            8'hFF, 1, 1, 1, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);
        dir_row(REQ_SPARE_HI,            8'hFF, 1, 1, 1, CHK_TYPED, 8'h00, 7'd0, 0, 8'h00);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            offer_word(row.w, row.typed, row.r);
        end

        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0, 1, 2, 7: ph = PH_FILL;
                3, 4, 8:    ph = PH_DRAIN;
                6:          ph = PH_NOISE;
                default:    ph = PH_MIX;
            endcase
            if (p == 1)
                stall_req = 1'b1;
            if (p == 5 || p == 7)
                wait_all_back();
            plen = $urandom_range(65, 85);
            for (n = 0; n < plen; n++)
            begin
                roll   = $urandom_range(0, 99);
                w.data = 8'($urandom_range(0, 255));
                w.fe   = 1'b0;
                w.pe   = 1'b0;
                w.pr   = 1'b1;
                case (ph)
                    PH_FILL:
                        if (roll < 50)      w.req = uartrb_pkg::REQ_RX_BYTE;
                        else if (roll < 85) w.req = uartrb_pkg::REQ_SEND;
                        else if (roll < 93) w.req = uartrb_pkg::REQ_PEEK;
                        else                w.req = uartrb_pkg::REQ_TX_DONE;
                    PH_DRAIN:
                        if (roll < 40)      w.req = uartrb_pkg::REQ_GET;
                        else if (roll < 75) w.req = uartrb_pkg::REQ_TX_DONE;
                        else if (roll < 85) w.req = uartrb_pkg::REQ_PEEK;
                        else if (roll < 95) w.req = uartrb_pkg::REQ_RX_BYTE;
                        else                w.req = uartrb_pkg::REQ_SEND;
                    PH_MIX:
                    begin
                        if (roll < 20)      w.req = uartrb_pkg::REQ_SEND;
                        else if (roll < 40) w.req = uartrb_pkg::REQ_GET;
                        else if (roll < 55) w.req = uartrb_pkg::REQ_PEEK;
                        else if (roll < 80) w.req = uartrb_pkg::REQ_RX_BYTE;
                        else                w.req = uartrb_pkg::REQ_TX_DONE;
                        // some receive bytes arrive broken
                        if ($urandom_range(0, 4) == 0)
                        begin
                            w.fe = 1'($urandom_range(0, 1));
                            w.pe = 1'($urandom_range(0, 1));
                            w.pr = 1'($urandom_range(0, 1));
                        end
                    end
                    default:
                    begin
                        w.req = 3'($urandom_range(0, 7));
                        w.fe  = 1'($urandom_range(0, 1));
                        w.pe  = 1'($urandom_range(0, 1));
                        w.pr  = 1'($urandom_range(0, 1));
                    end
                endcase
                offer_word(w, CHK_MODEL, '0);
            end
        end

        wait_all_back();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d words taken, %0d results checked, %0d transmitter loads",
                 words_taken, results_checked, tx_loads);
        $display("overwrites rx %0d tx %0d, peak rx fill %0d/%0d, %0d long output stalls",
                 overwrites[RING_RX], overwrites[RING_TX], peak_rx_fill, DEPTH, stalls_done);
        if (errors == 0)
            $display("uart_rx_tx_ring_buffers_top_tb: clean");
        else
            $display("uart_rx_tx_ring_buffers_top_tb: errors");
        $finish;
    end

    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results pending", expect_q.size());
        $display("uart_rx_tx_ring_buffers_top_tb: errors");
        $finish;
    end

endmodule
